### rtl/histogram_valley_threshold_unit_defines.svh
`ifndef HISTOGRAM_VALLEY_THRESHOLD_UNIT_DEFINES_SVH
`define HISTOGRAM_VALLEY_THRESHOLD_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hvt assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define HVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hvt assertion failed");

`endif

### rtl/hvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hvt_pkg;

  localparam int COUNT_BITS = 21;
  localparam int NUM_BINS   = 256;
  localparam int BIN_W      = 8;
  localparam int LIMIT_W    = 21;
  localparam int LEVEL_W    = 9;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(500);
  localparam logic [LEVEL_W-1:0]    NO_VALLEY   = LEVEL_W'(256);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [BIN_W-1:0]      LAST_BIN    = '1;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [BIN_W-1:0] bin;
  } hvt_head_t;

  typedef struct packed {
    logic pop;
  } hvt_ctl_t;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_PEAK,
    ST_WALK,
    ST_EMIT
  } hvt_state_e;

endpackage

`default_nettype wire

### rtl/hvt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hvt_front import hvt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [BIN_W-1:0] pixel_value_i,
  input  wire logic             frame_last_i,
  input  wire hvt_ctl_t         ctl_i,
  output hvt_head_t             head_o
);

  logic [BIN_W:0]   q_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               push;
  logic               pop;

  assign in_stall_o = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctl_i.pop;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.last  = q_mem[rd_ptr_q][BIN_W];
  assign head_o.bin   = q_mem[rd_ptr_q][BIN_W-1:0];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= {frame_last_i, pixel_value_i};
    end
  end

endmodule

`default_nettype wire

### rtl/hvt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hvt_back import hvt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hvt_head_t          head_i,
  output hvt_ctl_t                ctl_o,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [LEVEL_W-1:0]      threshold_level_o
);

  hvt_state_e state_q, state_d;

  count_t             hist_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_vld_q, bin_vld_d;
  count_t             rd_data_q;
  logic               rdv_q;

  logic               s2_vld_q;
  logic [BIN_W-1:0]   s2_bin_q;
  logic               wb_vld_q;
  logic [BIN_W-1:0]   wb_addr_q;
  count_t             wb_val_q;

  logic [BIN_W:0]     scan_q, scan_d;
  logic               sc_vld_q;
  logic [BIN_W-1:0]   sc_idx_q;
  count_t             best_q, best_d;
  logic [BIN_W-1:0]   peak_q, peak_d;
  count_t             prev_q, prev_d;
  logic [LEVEL_W-1:0] res_q, res_d;
  logic               out_vld_q, out_vld_d;
  logic [LEVEL_W-1:0] out_lvl_q;

  logic               pop;
  logic               rd_en;
  logic [BIN_W-1:0]   rd_addr;
  count_t             cur_rd;
  count_t             base;
  count_t             inc_val;
  logic               scan_issue;
  logic               last_cmp;
  logic               gt_best;
  count_t             best_new;
  logic [BIN_W-1:0]   peak_new;
  logic               hit;
  logic               peak_done;
  logic               walk_done;
  logic               emit_load;

  assign pop       = (state_q == ST_COUNT) && head_i.valid;
  assign ctl_o.pop = pop;

  assign cur_rd  = rdv_q ? rd_data_q : '0;
  assign base    = (wb_vld_q && (wb_addr_q == s2_bin_q)) ? wb_val_q : cur_rd;
  assign inc_val = (base == COUNT_MAX) ? base : base + 1'b1;

  assign last_cmp  = sc_vld_q && (sc_idx_q == LAST_BIN);
  assign gt_best   = cur_rd > best_q;
  assign best_new  = (sc_vld_q && gt_best) ? cur_rd : best_q;
  assign peak_new  = (sc_vld_q && gt_best) ? sc_idx_q : peak_q;
  assign hit       = sc_vld_q && (CMP_W'(cur_rd) < CMP_W'(limit_i)) && (cur_rd > prev_q);
  assign peak_done = (state_q == ST_PEAK) && last_cmp;
  assign walk_done = (state_q == ST_WALK) && (hit || last_cmp);
  assign emit_load = (state_q == ST_EMIT) && (!out_vld_q || !out_stall_i);

  assign scan_issue = ((state_q == ST_PEAK) || (state_q == ST_WALK)) && !scan_q[BIN_W]
                      && !walk_done;
  assign rd_addr    = (state_q == ST_COUNT) ? head_i.bin : scan_q[BIN_W-1:0];
  assign rd_en      = pop || scan_issue;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COUNT: begin
        if (pop && head_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_PEAK;
      end
      ST_PEAK: begin
        if (peak_done) begin
          state_d = (peak_new == LAST_BIN) ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_d = ST_COUNT;
        end
      end
      default: begin
        state_d = ST_COUNT;
      end
    endcase
  end

  always_comb begin
    scan_d    = scan_issue ? scan_q + 1'b1 : scan_q;
    best_d    = best_q;
    peak_d    = peak_q;
    prev_d    = prev_q;
    res_d     = res_q;
    bin_vld_d = bin_vld_q;
    if (s2_vld_q) begin
      bin_vld_d[s2_bin_q] = 1'b1;
    end
    unique case (state_q)
      ST_COUNT: begin
      end
      ST_DRAIN: begin
        scan_d = '0;
        best_d = '0;
        peak_d = '0;
      end
      ST_PEAK: begin
        best_d = best_new;
        peak_d = peak_new;
        if (peak_done) begin
          scan_d = (BIN_W + 1)'(peak_new) + 1'b1;
          prev_d = best_new;
          res_d  = NO_VALLEY;
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_d = LEVEL_W'(sc_idx_q) - 1'b1;
        end else if (sc_vld_q) begin
          prev_d = cur_rd;
          if (last_cmp) begin
            res_d = NO_VALLEY;
          end
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          bin_vld_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (emit_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COUNT;
      bin_vld_q <= '0;
      s2_vld_q  <= 1'b0;
      wb_vld_q  <= 1'b0;
      sc_vld_q  <= 1'b0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bin_vld_q <= bin_vld_d;
      s2_vld_q  <= pop;
      wb_vld_q  <= s2_vld_q;
      sc_vld_q  <= scan_issue;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
      rdv_q     <= bin_vld_q[rd_addr];
    end
    if (s2_vld_q) begin
      hist_mem[s2_bin_q] <= inc_val;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_bin_q  <= head_i.bin;
    wb_addr_q <= s2_bin_q;
    wb_val_q  <= inc_val;
    sc_idx_q  <= scan_q[BIN_W-1:0];
    best_q    <= best_d;
    peak_q    <= peak_d;
    prev_q    <= prev_d;
    res_q     <= res_d;
    if (emit_load) begin
      out_lvl_q <= res_q;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign threshold_level_o = out_lvl_q;

endmodule

`default_nettype wire

### rtl/histogram_valley_threshold_unit.sv
// Pixels: one request per cycle while the four-deep queue before the counter has room.
// Each pixel takes a registered read of its bin, then the increment in the next cycle.
// Frame end: a drain state, a peak sweep over all 256 bins, then a valley walk after
// the peak, one bin per cycle through the single histogram read port, then emit.
// Reset clears the histogram at once through per-bin valid bits; limit resets to 500.
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_valley_threshold_unit_defines.svh"

module histogram_valley_threshold_unit import hvt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [BIN_W-1:0]   pixel_value_i,
  input  wire logic               frame_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [LEVEL_W-1:0]      threshold_level_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LIMIT_W-1:0] cfg_valley_count_limit_i
);

  hvt_head_t          head;
  hvt_ctl_t           ctl;
  logic [LIMIT_W-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_valley_count_limit_i;
    end
  end

  hvt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .frame_last_i  (frame_last_i),
    .ctl_i         (ctl),
    .head_o        (head)
  );

  hvt_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .ctl_o             (ctl),
    .limit_i           (limit_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .threshold_level_o (threshold_level_o)
  );

  `HVT_ASSERT_IMPL(a_pop_needs_head, ctl.pop, head.valid)
  `HVT_ASSERT_IMPL(a_full_has_head, in_stall_o, head.valid)
  `HVT_ASSERT_NEXT(a_last_pop_blocks, ctl.pop && head.last, !ctl.pop)

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hvt_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 600;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef enum int {
    MIX_FLAT,
    MIX_TWO_PEAKS
  } pixel_mix_e;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [BIN_W-1:0]   pixel_value     = '0;
  logic               frame_last      = 1'b0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [LEVEL_W-1:0] threshold_level;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_limit       = LIMIT_RESET;

  logic [COUNT_BITS-1:0] shadow_bins [NUM_BINS];
  logic [LIMIT_W-1:0]    limit_q;
  logic [LEVEL_W-1:0]    expected_levels [$];

  int fail_cnt    = 0;
  int rx_hold_len = 0;
  bit rx_idle_en  = 1'b1;
  bit tx_idle_en  = 1'b1;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  histogram_valley_threshold_unit i_dut (
    .clk_i                    (clk),
    .rst_ni                   (rst_n),
    .in_valid_i               (in_valid),
    .in_stall_o               (in_stall),
    .pixel_value_i            (pixel_value),
    .frame_last_i             (frame_last),
    .out_valid_o              (out_valid),
    .out_stall_i              (out_stall),
    .threshold_level_o        (threshold_level),
    .cfg_valid_i              (cfg_valid),
    .cfg_ready_o              (cfg_ready),
    .cfg_valley_count_limit_i (cfg_limit)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [LEVEL_W-1:0] predict_level();
    int                    peak;
    logic [COUNT_BITS-1:0] prev;
    peak = 0;
    for (int b = 1; b < NUM_BINS; b++) begin
      if (shadow_bins[b] > shadow_bins[peak]) peak = b;
    end
    prev = shadow_bins[peak];
    for (int b = peak; b < NUM_BINS; b++) begin
      if (shadow_bins[b] < limit_q && shadow_bins[b] > prev) return LEVEL_W'(b - 1);
      prev = shadow_bins[b];
    end
    return NO_VALLEY;
  endfunction

  function automatic void tally_pixel(input logic [BIN_W-1:0] value, input logic last);
    if (shadow_bins[value] != COUNT_MAX) shadow_bins[value] = shadow_bins[value] + 1'b1;
    if (last) begin
      expected_levels = {expected_levels, predict_level()};
      foreach (shadow_bins[b]) shadow_bins[b] = '0;
    end
  endfunction

  function automatic logic [BIN_W-1:0] pick_pixel(input pixel_mix_e mix, input int c0,
                                                  input int c1, input int spread);
    int v;
    if (mix == MIX_FLAT) begin
      v = $urandom_range(0, 255);
    end else begin
      v = (($urandom_range(0, 2) != 0) ? c0 : c1) + $urandom_range(0, 2 * spread) - spread;
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[BIN_W-1:0];
  endfunction

  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic send_pixel(input logic [BIN_W-1:0] value, input logic last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= value;
    frame_last  <= last;
    do @(posedge clk); while (in_stall);
    tally_pixel(value, last);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [BIN_W-1:0] values [$]);
    foreach (values[k]) send_pixel(values[k], k == values.size() - 1);
  endtask

  task automatic send_random_frames(input int n_items);
    int         sent;
    int         len;
    int         c0;
    int         c1;
    int         spread;
    pixel_mix_e mix;
    sent = 0;
    while (sent < n_items) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
      mix    = ($urandom_range(0, 3) == 0) ? MIX_FLAT : MIX_TWO_PEAKS;
      c0     = $urandom_range(0, 255);
      c1     = $urandom_range(0, 255);
      spread = $urandom_range(0, 10);
      for (int k = 0; k < len; k++) send_pixel(pick_pixel(mix, c0, c1, spread), k == len - 1);
      sent += len;
    end
  endtask

  task automatic test_directed_frames();
    send_frame('{8'd0});
    send_frame('{8'd255});
    send_frame('{8'd10, 8'd10, 8'd12});
    send_frame('{8'd250, 8'd250, 8'd254, 8'd255, 8'd255});
    // tie between two peaks: lower index wins
    send_frame('{8'd20, 8'd40, 8'd20, 8'd40, 8'd41});
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    write_limit('0);
    send_frame('{8'd10, 8'd10, 8'd12});
    write_limit(LIMIT_MAX);
    send_frame('{8'd10, 8'd10, 8'd12});
    write_limit(LIMIT_W'(1));
    send_frame('{8'd10, 8'd10, 8'd12});
    wait_idle();
  endtask

  task automatic test_random_frames();
    logic [LIMIT_W-1:0] lim;
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0:       lim = LIMIT_W'($urandom_range(1, 8));
        1:       lim = LIMIT_W'($urandom_range(2, 60));
        default: lim = LIMIT_W'($urandom_range(0, int'(LIMIT_MAX)));
      endcase
      write_limit(lim);
      send_random_frames(110);
    end
    write_limit(LIMIT_RESET);
    send_random_frames(60);
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    rx_hold_len = HOLD_CYCLES;
    tx_idle_en  = 1'b0;
    for (int f = 0; f < 4; f++) send_random_frames(6);
    tx_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_full_rate();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    send_random_frames(80);
    wait_idle();
  endtask

  initial begin : result_stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        n           = rx_hold_len;
        rx_hold_len = 0;
        out_stall  <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall  <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        n          = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_levels
    logic [LEVEL_W-1:0] want;
    if (rst_n && out_fire) begin
      if (expected_levels.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
          $display("unexpected threshold %0d at %0t", threshold_level, $realtime);
        end
      end else begin
        want = expected_levels.pop_front();
        if (threshold_level !== want) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT) begin
            $display("threshold mismatch at %0t: expected %0d, got %0d",
                     $realtime, want, threshold_level);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire || cfg_fire) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    foreach (shadow_bins[b]) shadow_bins[b] = '0;
    limit_q = LIMIT_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_limit_extremes();
    test_random_frames();
    test_output_hold_off();
    test_full_rate();

    if (fail_cnt == 0 && expected_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### histogram_valley_threshold_unit.f
+incdir+rtl
rtl/hvt_pkg.sv
rtl/hvt_front.sv
rtl/hvt_back.sv
rtl/histogram_valley_threshold_unit.sv
tb/testbench.sv
